FILE: hdl/bwf_pkg.sv
// Shared constants, types and helper functions for the blocked word filter.
`timescale 1ns / 1ps
package bwf_pkg;

  localparam int MAX_TOKEN_LEN = 32;
  localparam int MAX_WORD_LEN  = 10;
  localparam int NUM_BLOCKED   = 4;
  localparam int NUM_ALLOWED   = 4;

  localparam int NUM_WORDS  = 8;
  localparam int ALLOW_BASE = NUM_WORDS / 2;
  localparam int CODE_W     = 6;
  localparam int WORD_W     = CODE_W * MAX_WORD_LEN;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = $clog2(NUM_WORDS);
  localparam int LEN_W      = $clog2(MAX_TOKEN_LEN + 1);
  localparam int WL_W       = $clog2(MAX_WORD_LEN + 1);

  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_UP_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_LO_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LO_Z   = 8'h7A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] LETTER_BASE = 8'd1;
  localparam logic [BYTE_W-1:0] DIGIT_BASE  = 8'd27;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } bwf_cmd_t;

  typedef struct packed {
    logic last;
  } bwf_stat_t;

  // 1-26 for letters (either case), 27-36 for digits, 0 for anything else
  function automatic logic [CODE_W-1:0] char_code(input logic [BYTE_W-1:0] b_in);
    logic [CODE_W-1:0] code;
    code = '0;
    if (b_in inside {[CHAR_UP_A:CHAR_UP_Z]}) begin
      code = CODE_W'(b_in - CHAR_UP_A + LETTER_BASE);
    end else if (b_in inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
      code = CODE_W'(b_in - CHAR_LO_A + LETTER_BASE);
    end else if (b_in inside {[CHAR_ZERO:CHAR_NINE]}) begin
      code = CODE_W'(b_in - CHAR_ZERO + DIGIT_BASE);
    end
    return code;
  endfunction

  function automatic logic [WL_W-1:0] word_len(input logic [WORD_W-1:0] w);
    logic [WL_W-1:0] n;
    n = WL_W'(MAX_WORD_LEN);
    for (int i = MAX_WORD_LEN - 1; i >= 0; i--) begin
      if (w[CODE_W*i +: CODE_W] == '0) n = WL_W'(i);
    end
    return n;
  endfunction

  // bit len-1 set; zero for an empty word
  function automatic logic [MAX_WORD_LEN-1:0] len_onehot(input logic [WL_W-1:0] len);
    logic [MAX_WORD_LEN-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      if (len == WL_W'(i + 1)) m[i] = 1'b1;
    end
    return m;
  endfunction

  // bits below len set
  function automatic logic [MAX_WORD_LEN-1:0] below_mask(input logic [WL_W-1:0] len);
    logic [MAX_WORD_LEN-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      if (WL_W'(i) < len) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

FILE: hdl/bwf_in_if.sv
// Name byte input channel.
`timescale 1ns / 1ps
interface bwf_in_if;
  logic                      valid;
  logic                      ready;
  logic [bwf_pkg::BYTE_W-1:0] name_byte;
  logic                      last_byte;

  modport source (output valid, name_byte, last_byte, input ready);
  modport sink   (input valid, name_byte, last_byte, output ready);
endinterface

FILE: hdl/bwf_out_if.sv
// Verdict output channel.
`timescale 1ns / 1ps
interface bwf_out_if;
  logic valid;
  logic ready;
  logic contains_blocked;
  logic token_overflow;

  modport source (output valid, contains_blocked, token_overflow, input ready);
  modport sink   (input valid, contains_blocked, token_overflow, output ready);
endinterface

FILE: hdl/bwf_cfg_if.sv
// Word register write channel.
`timescale 1ns / 1ps
interface bwf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bwf_pkg::CFG_IDX_W-1:0] index;
  logic [bwf_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/bwf_ctrl.sv
// Byte sequencing and output handshake control.
`timescale 1ns / 1ps
module bwf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bwf_pkg::bwf_stat_t stat,
  output bwf_pkg::bwf_cmd_t  cmd
);

  typedef enum logic [0:0] {S_IDLE, S_STEP} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        // a final byte waits while the previous verdict is still held
        if (!(stat.last && out_valid_r && !out_ready)) begin
          cmd.step  = 1'b1;
          cmd.emit  = stat.last;
          state_nxt = S_IDLE;
          if (stat.last) out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/bwf_datapath.sv
// Word registers, character decode, streaming word matchers and verdict registers.
`timescale 1ns / 1ps
module bwf_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bwf_pkg::bwf_cmd_t             cmd,
  output bwf_pkg::bwf_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [bwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bwf_pkg::WORD_W-1:0]    cfg_data,
  input  logic [bwf_pkg::BYTE_W-1:0]    name_byte,
  input  logic                          last_byte,
  output logic                          contains_blocked,
  output logic                          token_overflow
);

  localparam int MWL = bwf_pkg::MAX_WORD_LEN;

  logic [bwf_pkg::WORD_W-1:0] word_r [bwf_pkg::NUM_WORDS];
  logic [bwf_pkg::WL_W-1:0]   wlen   [bwf_pkg::NUM_WORDS];
  logic [MWL-1:0]             eqv    [bwf_pkg::NUM_WORDS];
  logic [MWL-1:0]             part_r [bwf_pkg::NUM_WORDS];
  logic [MWL-1:0]             part_nxt [bwf_pkg::NUM_WORDS];

  logic [bwf_pkg::BYTE_W-1:0] byte_r;
  logic                       last_r;
  logic [bwf_pkg::LEN_W-1:0]  len_r;
  logic [MWL-1:0]             pend_r, pend_upd, blk_add, alw_clr;
  logic [MWL:0]               pend_sh;
  logic                       verdict_r, verdict_nxt, ovf_r, ovf_nxt;
  logic                       contains_r, overflow_r;

  logic [bwf_pkg::CODE_W-1:0] ch;
  logic is_char, is_space, room, take, spill, tok_end, tok_fail;

  assign ch       = bwf_pkg::char_code(byte_r);
  assign is_char  = ch != '0;
  assign is_space = byte_r == bwf_pkg::CHAR_SPACE;
  assign room     = len_r != bwf_pkg::LEN_W'(bwf_pkg::MAX_TOKEN_LEN);
  assign take     = cmd.step && is_char && room;
  assign tok_end  = cmd.step && (is_space || last_r);

  // shift-and matchers: part bit i set when the word's first i+1 codes end here
  always_comb begin
    logic [MWL:0] sh;
    logic         hit;
    blk_add = '0;
    alw_clr = '0;
    for (int k = 0; k < bwf_pkg::NUM_WORDS; k++) begin
      wlen[k] = bwf_pkg::word_len(word_r[k]);
      for (int i = 0; i < MWL; i++) begin
        eqv[k][i] = (word_r[k][bwf_pkg::CODE_W*i +: bwf_pkg::CODE_W] == ch) &&
                    (bwf_pkg::WL_W'(i) < wlen[k]);
      end
      sh          = {part_r[k], 1'b1};
      part_nxt[k] = sh[MWL-1:0] & eqv[k];
      hit         = |(part_nxt[k] & bwf_pkg::len_onehot(wlen[k]));
      if (k < bwf_pkg::NUM_BLOCKED && hit) begin
        blk_add = blk_add | bwf_pkg::len_onehot(wlen[k]);
      end
      if (k >= bwf_pkg::ALLOW_BASE && k < bwf_pkg::ALLOW_BASE + bwf_pkg::NUM_ALLOWED && hit) begin
        alw_clr = alw_clr | bwf_pkg::below_mask(wlen[k]);
      end
    end
  end

  // pending blocked starts, bit d = start d positions back; an allowed hit
  // clears every pending start at or after its own start
  assign pend_sh  = {pend_r, 1'b0};
  assign spill    = take && pend_sh[MWL];
  assign pend_upd = take ? ((pend_sh[MWL-1:0] | blk_add) & ~alw_clr) : pend_r;
  assign tok_fail = tok_end && (|pend_upd);

  assign verdict_nxt = verdict_r || spill || tok_fail;
  assign ovf_nxt     = ovf_r || (cmd.step && is_char && !room);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= name_byte;
      last_r <= last_byte;
    end
    if (cmd.emit) begin
      contains_r <= verdict_nxt;
      overflow_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bwf_pkg::NUM_WORDS; k++) begin
        word_r[k] <= '0;
        part_r[k] <= '0;
      end
      len_r     <= '0;
      pend_r    <= '0;
      verdict_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      if (cfg_we) word_r[cfg_index] <= cfg_data;
      if (tok_end) begin
        len_r  <= '0;
        pend_r <= '0;
        for (int k = 0; k < bwf_pkg::NUM_WORDS; k++) part_r[k] <= '0;
      end else if (take) begin
        len_r  <= len_r + bwf_pkg::LEN_W'(1);
        pend_r <= pend_upd;
        for (int k = 0; k < bwf_pkg::NUM_WORDS; k++) part_r[k] <= part_nxt[k];
      end
      if (cmd.emit) begin
        verdict_r <= 1'b0;
        ovf_r     <= 1'b0;
      end else if (cmd.step) begin
        verdict_r <= verdict_nxt;
        ovf_r     <= ovf_nxt;
      end
    end
  end

  assign stat.last        = last_r;
  assign contains_blocked = contains_r;
  assign token_overflow   = overflow_r;

endmodule

FILE: hdl/blocked_word_filter_with_allow_list.sv
// Top level of the blocked word filter with allow list.
`timescale 1ns / 1ps
// Name bytes enter one per transfer; each byte is first registered and then passed through
// the single match stage that runs all eight word matchers on the new character, and the
// input takes no new byte until that step is done. A final byte also waits while the
// previous verdict is still held in the output register. One verdict per name is given
// after its final byte; register writes are always accepted and take effect at once.
module blocked_word_filter_with_allow_list (
  input  logic       clk,
  input  logic       rst_n,
  bwf_in_if.sink     in_chan,
  bwf_out_if.source  out_chan,
  bwf_cfg_if.sink    cfg_chan
);

  bwf_pkg::bwf_cmd_t  cmd;
  bwf_pkg::bwf_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  bwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bwf_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_chan.valid),
    .cfg_index        (cfg_chan.index),
    .cfg_data         (cfg_chan.data),
    .name_byte        (in_chan.name_byte),
    .last_byte        (in_chan.last_byte),
    .contains_blocked (out_chan.contains_blocked),
    .token_overflow   (out_chan.token_overflow)
  );

endmodule

FILE: hdl/bwf_checker.sv
// Port-level checks for the blocked word filter, bound to the top level.
`timescale 1ns / 1ps
module bwf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_contains,
  input logic out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_contains) && $stable(out_overflow))
    else $error("verdict changed while stalled");

  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second byte taken while one is in progress");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> ##1 !$rose(out_valid))
    else $error("verdict raised for a byte that is not final");

endmodule

bind blocked_word_filter_with_allow_list bwf_checker u_bwf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_last      (in_chan.last_byte),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_contains (out_chan.contains_blocked),
  .out_overflow (out_chan.token_overflow)
);

FILE: bench/blocked_word_filter_with_allow_list_tb.sv
// Self-checking bench for the blocked word filter: directed and random names against a predictor.
`timescale 1ns / 1ps
module blocked_word_filter_with_allow_list_tb;
  import bwf_pkg::*;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef struct packed {
    logic contains_blocked;
    logic token_overflow;
  } verdict_t;

  localparam int unsigned GAP_MAX      = 12;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 1700;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned QUIET_PHASE  = 2;

  localparam code_t CODE_END = 6'd0;
  localparam code_t CODE_A   = 6'd1;
  localparam code_t CODE_D   = 6'd4;
  localparam code_t CODE_0   = 6'd27;
  localparam code_t CODE_1   = 6'd28;
  localparam code_t CODE_9   = 6'd36;
  localparam code_t CODE_MAX = 6'd63;

  logic clk = 1'b0;
  logic rst_n;

  bwf_in_if  in_chan();
  bwf_out_if out_chan();
  bwf_cfg_if cfg_chan();

  blocked_word_filter_with_allow_list uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  word_t       word_regs [NUM_WORDS];
  code_t       tok_codes [MAX_TOKEN_LEN];
  int unsigned tok_len = 0;
  logic        name_blocked = 1'b0;
  logic        name_overflow = 1'b0;
  verdict_t    verdicts_due [$];

  word_t       next_words [NUM_WORDS];
  logic [7:0]  name_bytes [$];
  int unsigned bytes_sent = 0;
  int unsigned fail_count = 0;
  int unsigned cycles = 0;
  logic        in_gaps_on = 1'b1;
  logic        out_stalls_on = 1'b1;
  logic        long_hold_req = 1'b0;

  function automatic int unsigned count_codes(word_t w);
    int unsigned n;
    n = 0;
    while (n < MAX_WORD_LEN && w[CODE_W*n +: CODE_W] != CODE_END) n++;
    return n;
  endfunction

  function automatic bit word_at(word_t w, int unsigned wl, int unsigned pos);
    if (wl > tok_len || pos + wl > tok_len) return 1'b0;
    for (int unsigned i = 0; i < wl; i++) begin
      if (tok_codes[pos + i] != w[CODE_W*i +: CODE_W]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit allowed_covers(int unsigned pos, int unsigned bl);
    word_t       a;
    int unsigned al;
    for (int k = 0; k < NUM_ALLOWED; k++) begin
      a  = word_regs[ALLOW_BASE + k];
      al = count_codes(a);
      if (al == 0 || al < bl || al > tok_len) continue;
      for (int unsigned p = 0; p <= pos && p + al <= tok_len; p++) begin
        if (pos + bl <= p + al && word_at(a, al, p)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit token_blocked();
    word_t       b;
    int unsigned bl;
    for (int k = 0; k < NUM_BLOCKED; k++) begin
      b  = word_regs[k];
      bl = count_codes(b);
      if (bl == 0 || bl > tok_len) continue;
      for (int unsigned pos = 0; pos + bl <= tok_len; pos++) begin
        if (word_at(b, bl, pos) && !allowed_covers(pos, bl)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void close_token();
    if (token_blocked()) name_blocked = 1'b1;
    tok_len = 0;
  endfunction

  function automatic code_t fold_char(logic [7:0] b);
    if (b >= CHAR_UP_A && b <= CHAR_UP_Z) return code_t'(b - CHAR_UP_A + LETTER_BASE);
    if (b >= CHAR_LO_A && b <= CHAR_LO_Z) return code_t'(b - CHAR_LO_A + LETTER_BASE);
    if (b >= CHAR_ZERO && b <= CHAR_NINE) return code_t'(b - CHAR_ZERO + DIGIT_BASE);
    return CODE_END;
  endfunction

  function automatic void absorb_byte(logic [7:0] b, logic last);
    code_t c;
    c = fold_char(b);
    if (b == CHAR_SPACE) begin
      close_token();
    end else if (c != CODE_END) begin
      if (tok_len < MAX_TOKEN_LEN) begin
        tok_codes[tok_len] = c;
        tok_len++;
      end else begin
        name_overflow = 1'b1;
      end
    end
    if (last) begin
      close_token();
      verdicts_due = {verdicts_due, verdict_t'({name_blocked, name_overflow})};
      name_blocked  = 1'b0;
      name_overflow = 1'b0;
    end
  endfunction

  function automatic word_t spell(string s);
    word_t w;
    w = '0;
    for (int i = 0; i < s.len() && i < MAX_WORD_LEN; i++) w[CODE_W*i +: CODE_W] = fold_char(s[i]);
    return w;
  endfunction

  function automatic code_t rand_code(bit narrow);
    if (!narrow) return code_t'($urandom_range(CODE_A, CODE_9));
    if ($urandom_range(0, 3) == 0) return code_t'($urandom_range(CODE_0, CODE_1));
    return code_t'($urandom_range(CODE_A, CODE_D));
  endfunction

  function automatic word_t rand_word();
    word_t       w;
    int unsigned len, pick;
    w    = '0;
    pick = $urandom_range(0, 19);
    if (pick == 0) return w;
    if (pick == 1) return word_t'({$urandom, $urandom});
    if (pick == 2) begin
      // empty word with junk above the terminator
      w = word_t'({$urandom, $urandom});
      w[CODE_W-1:0] = CODE_END;
      return w;
    end
    len = (pick == 3) ? MAX_WORD_LEN : $urandom_range(1, 4);
    for (int unsigned i = 0; i < len; i++) w[CODE_W*i +: CODE_W] = rand_code(pick != 3);
    if (pick == 4) begin
      w[CODE_W*$urandom_range(0, len - 1) +: CODE_W] =
        code_t'($urandom_range(CODE_9 + 1, CODE_MAX));
    end
    return w;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    name_bytes = {name_bytes, b};
  endfunction

  function automatic void add_char(code_t c);
    if ($urandom_range(0, 9) == 0) put_byte(8'($urandom_range(0, 255)));
    if (c == CODE_END || c > CODE_9) return;
    if (c >= CODE_0) put_byte(CHAR_ZERO + 8'(c - CODE_0));
    else put_byte(($urandom_range(0, 2) == 0 ? CHAR_UP_A : CHAR_LO_A) + 8'(c - CODE_A));
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.name_byte <= b;
    in_chan.last_byte <= last;
    do @(posedge clk); while (!in_chan.ready);
    absorb_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_name();
    int unsigned n;
    if (name_bytes.size() == 0) put_byte(CHAR_SPACE);
    n = name_bytes.size();
    for (int unsigned i = 0; i < n; i++) send_byte(name_bytes[i], i == n - 1);
    name_bytes.delete();
  endtask

  task automatic send_text(string s);
    add_text(s);
    send_name();
  endtask

  task automatic send_random_name();
    word_t w;
    int    n_tok;
    n_tok = $urandom_range(1, 3);
    if ($urandom_range(0, 7) == 0) put_byte(CHAR_SPACE);
    for (int t = 0; t < n_tok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 2)) put_byte(CHAR_SPACE);
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(MAX_TOKEN_LEN - 2, MAX_TOKEN_LEN + 8)) add_char(rand_code(1'b1));
        continue;
      end
      repeat ($urandom_range(0, 3)) add_char(rand_code(1'b1));
      if ($urandom_range(0, 4) != 0) begin
        w = word_regs[$urandom_range(0, NUM_WORDS - 1)];
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
          if (w[CODE_W*i +: CODE_W] == CODE_END) break;
          add_char(w[CODE_W*i +: CODE_W]);
        end
      end
      repeat ($urandom_range(0, 3)) add_char(rand_code(1'b1));
    end
    if ($urandom_range(0, 7) == 0) put_byte(CHAR_SPACE);
    send_name();
  endtask

  task automatic write_words();
    for (int i = 0; i < NUM_WORDS; i++) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= CFG_IDX_W'(i);
      cfg_chan.data  <= next_words[i];
      do @(posedge clk); while (!cfg_chan.ready);
      word_regs[i] = next_words[i];
    end
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_reset_words();
    send_text("bad Q");
    send_text(" ");
    wait_idle();
  endtask

  task automatic test_directed_names();
    next_words[0] = spell("bad");
    next_words[1] = spell("ass");
    next_words[2] = spell("q");
    next_words[3] = spell("abcdefghij");
    next_words[ALLOW_BASE + 0] = spell("badge");
    next_words[ALLOW_BASE + 1] = spell("class");
    next_words[ALLOW_BASE + 2] = spell("bad") << CODE_W;
    next_words[ALLOW_BASE + 3] = spell("as");
    write_words();
    send_text("BaD");
    send_text("badge");
    send_text("Classic");
    send_text("bass");
    name_bytes = '{"b", 8'h00, "a", 8'h7f, "d"};
    send_name();
    send_text("ba@[`{/: d");
    send_text(" ");
    name_bytes = '{"q", 8'hff};
    send_name();
    name_bytes = '{8'hc3, 8'ha9, 8'h80};
    send_name();
    send_text("ABCDEFGHIJ");
    send_text("z09Z");
    send_text("xxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxbad");
    send_text("ok");
    wait_idle();
  endtask

  task automatic test_extreme_words();
    for (int i = 0; i < NUM_WORDS; i++) next_words[i] = '1;
    write_words();
    send_text("bad q9");
    wait_idle();
  endtask

  task automatic test_random_names();
    int unsigned stop_at;
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < NUM_WORDS; i++) next_words[i] = rand_word();
      write_words();
      in_gaps_on    = (ph != QUIET_PHASE);
      out_stalls_on = (ph != QUIET_PHASE);
      stop_at = bytes_sent + RANDOM_BYTES / PHASES;
      while (bytes_sent < stop_at) send_random_name();
      wait_idle();
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // sink holds off while the next name's final byte waits behind the held verdict
  task automatic test_backpressure();
    in_gaps_on    = 1'b0;
    long_hold_req = 1'b1;
    repeat (6) send_random_name();
    wait_idle();
    in_gaps_on = 1'b1;
  endtask

  initial begin : verdict_sink
    int unsigned stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        stall = out_stalls_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict transfer: contains_blocked=%0b token_overflow=%0b",
               out_chan.contains_blocked, out_chan.token_overflow);
        fail_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_chan.contains_blocked !== want.contains_blocked) begin
          $error("contains_blocked: expected %0b, actual %0b",
                 want.contains_blocked, out_chan.contains_blocked);
          fail_count++;
        end
        if (out_chan.token_overflow !== want.token_overflow) begin
          $error("token_overflow: expected %0b, actual %0b",
                 want.token_overflow, out_chan.token_overflow);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("blocked_word_filter_with_allow_list regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_WORDS; i++) word_regs[i] = '0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.name_byte  <= '0;
    in_chan.last_byte  <= 1'b0;
    cfg_chan.valid     <= 1'b0;
    cfg_chan.index     <= '0;
    cfg_chan.data      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_words();
    test_directed_names();
    test_extreme_words();
    test_random_names();
    test_backpressure();
    if (fail_count == 0) begin
      $display("blocked_word_filter_with_allow_list regression: pass");
    end else begin
      $display("blocked_word_filter_with_allow_list regression: fail");
    end
    $finish;
  end

endmodule
